>>> src/macs_pkg.sv
// Shared types, codes and constants for the moving-average crossover signal block.
`default_nettype none

package macs_pkg;

    // Default structural sizes.
    localparam int MAX_WINDOW_DEF = 256;
    localparam int PRICE_BITS_DEF = 32;

    // Fixed field widths.
    localparam int PRICE_IN_W = 32;
    localparam int THETA_W    = 16;
    localparam int WIN_W      = 9;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int SIG_W      = 2;

    // Register reset values.
    localparam logic [THETA_W-1:0] THETA_RST        = '0;
    localparam logic [WIN_W-1:0]   SHORT_WINDOW_RST = 9'd10;
    localparam logic [WIN_W-1:0]   LONG_WINDOW_RST  = 9'd30;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_THETA        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WINDOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_WINDOW  = 2'd2;

    // Trade signal codes.
    localparam logic [SIG_W-1:0] SIG_NONE = 2'd0;
    localparam logic [SIG_W-1:0] SIG_BUY  = 2'd1;
    localparam logic [SIG_W-1:0] SIG_SELL = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_MUL1,
        ST_MUL2,
        ST_COMPARE
    } macs_state_t;

    typedef struct packed {
        logic accept;
        logic update;
        logic mul1;
        logic mul2;
        logic load_out;
    } macs_cmd_t;

endpackage

`default_nettype wire

>>> src/macs_ctrl.sv
// Sequencing controller and output valid flag for the crossover signal block.
`default_nettype none

module macs_ctrl
    import macs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  wire logic      out_stall,
    output macs_cmd_t      cmd
);

    macs_state_t state_reg;
    macs_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;
    logic        can_accept;

    // The output slot can take a new result when empty or when its transaction completes now.
    assign out_free   = !out_valid_reg || !out_stall;
    assign can_accept = (state_reg == ST_IDLE) || ((state_reg == ST_COMPARE) && out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
                state_next = ST_MUL1;
            ST_MUL1:
                state_next = ST_MUL2;
            ST_MUL2:
                state_next = ST_COMPARE;
            ST_COMPARE:
            begin
                if (out_free)
                    state_next = in_valid ? ST_UPDATE : ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_stall       = !can_accept;
        cmd.accept     = in_valid && can_accept;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_UPDATE:
                cmd.update = 1'b1;
            ST_MUL1:
                cmd.mul1 = 1'b1;
            ST_MUL2:
                cmd.mul2 = 1'b1;
            ST_COMPARE:
            begin
                cmd.load_out = out_free;
                if (out_free)
                    out_valid_next = 1'b1;
            end
            default:
                cmd.update = 1'b0;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> src/macs_dp.sv
// Datapath: registers, price history, running sums and the cross-multiplied comparison.
`default_nettype none

module macs_dp
    import macs_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int PRICE_BITS = PRICE_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire macs_cmd_t             cmd,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [PRICE_IN_W-1:0] open_price,
    output logic      [SIG_W-1:0]      signal
);

    localparam int AW        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W     = $clog2(MAX_WINDOW + 1);
    localparam int WIN_CMP_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;
    localparam int EXT_W     = CNT_W + 1;
    localparam int SUM_W     = PRICE_BITS + CNT_W;
    localparam int PROD_W    = SUM_W + CNT_W;
    localparam int BT_W      = PROD_W + THETA_W;

    function automatic logic [CNT_W-1:0] eff_window(input logic [WIN_W-1:0] w);
        logic [WIN_CMP_W-1:0] w_ext;
        w_ext = WIN_CMP_W'(w);
        if (w == '0)
            return CNT_W'(1);
        else if (w_ext > WIN_CMP_W'(MAX_WINDOW))
            return CNT_W'(MAX_WINDOW);
        else
            return CNT_W'(w);
    endfunction

    // Slot n positions behind the write pointer, wrapping at the history depth.
    function automatic logic [AW-1:0] slot_back(input logic [AW-1:0] wp,
                                                input logic [CNT_W-1:0] n);
        logic [EXT_W-1:0] wp_ext;
        logic [EXT_W-1:0] n_ext;
        logic [EXT_W-1:0] slot;
        wp_ext = EXT_W'(wp);
        n_ext  = EXT_W'(n);
        if (wp_ext >= n_ext)
            slot = wp_ext - n_ext;
        else
            slot = wp_ext + EXT_W'(MAX_WINDOW) - n_ext;
        return slot[AW-1:0];
    endfunction

    // Configuration registers.
    logic [THETA_W-1:0]    theta_reg;
    logic [WIN_W-1:0]      short_win_reg;
    logic [WIN_W-1:0]      long_win_reg;
    logic                  win_write;

    // History state.
    logic [CNT_W-1:0]      tick_reg;
    logic [CNT_W-1:0]      tick_next;
    logic [AW-1:0]         wp_reg;
    logic [AW-1:0]         wp_next;
    logic [SUM_W-1:0]      short_sum_reg;
    logic [SUM_W-1:0]      short_sum_next;
    logic [SUM_W-1:0]      long_sum_reg;
    logic [SUM_W-1:0]      long_sum_next;
    logic [PRICE_BITS-1:0] hist_mem [MAX_WINDOW];

    // Working registers.
    logic [PRICE_BITS-1:0] price_reg;
    logic [PRICE_BITS-1:0] rd_short_reg;
    logic [PRICE_BITS-1:0] rd_long_reg;
    logic [PROD_W-1:0]     a_reg;
    logic [PROD_W-1:0]     a_next;
    logic [PROD_W-1:0]     b_reg;
    logic [PROD_W-1:0]     b_next;
    logic [BT_W-1:0]       bt_reg;
    logic [BT_W-1:0]       bt_next;
    logic [PROD_W-1:0]     mag_reg;
    logic [PROD_W-1:0]     mag_next;
    logic                  gt_reg;
    logic                  gt_next;
    logic [SIG_W-1:0]      signal_reg;
    logic [SIG_W-1:0]      signal_next;

    logic [CNT_W-1:0]      sw_eff;
    logic [CNT_W-1:0]      lw_eff;
    logic [AW-1:0]         addr_short;
    logic [AW-1:0]         addr_long;
    logic                  short_full;
    logic                  long_full;
    logic [SUM_W-1:0]      short_num;
    logic [SUM_W-1:0]      long_num;
    logic [CNT_W-1:0]      short_den;
    logic [CNT_W-1:0]      long_den;
    logic [BT_W-1:0]       lhs_scaled;

    assign sw_eff     = eff_window(short_win_reg);
    assign lw_eff     = eff_window(long_win_reg);
    assign addr_short = slot_back(wp_reg, sw_eff);
    assign addr_long  = slot_back(wp_reg, lw_eff);
    assign win_write  = cfg_we &&
                        ((cfg_index == CFG_SHORT_WINDOW) || (cfg_index == CFG_LONG_WINDOW));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            theta_reg     <= THETA_RST;
            short_win_reg <= SHORT_WINDOW_RST;
            long_win_reg  <= LONG_WINDOW_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_THETA:
                    theta_reg <= cfg_data[THETA_W-1:0];
                CFG_SHORT_WINDOW:
                    short_win_reg <= cfg_data[WIN_W-1:0];
                CFG_LONG_WINDOW:
                    long_win_reg <= cfg_data[WIN_W-1:0];
                default:
                    theta_reg <= theta_reg;
            endcase
        end
    end

    // Update of the window sums: the oldest price leaves a full window as the new one enters.
    always_comb
    begin
        tick_next      = tick_reg;
        wp_next        = wp_reg;
        short_sum_next = short_sum_reg;
        long_sum_next  = long_sum_reg;
        if (win_write)
        begin
            tick_next      = '0;
            wp_next        = '0;
            short_sum_next = '0;
            long_sum_next  = '0;
        end
        else if (cmd.update)
        begin
            short_sum_next = short_sum_reg + SUM_W'(price_reg)
                             - ((tick_reg >= sw_eff) ? SUM_W'(rd_short_reg) : SUM_W'(0));
            long_sum_next  = long_sum_reg + SUM_W'(price_reg)
                             - ((tick_reg >= lw_eff) ? SUM_W'(rd_long_reg) : SUM_W'(0));
            tick_next      = (tick_reg == CNT_W'(MAX_WINDOW)) ? tick_reg : tick_reg + CNT_W'(1);
            wp_next        = (wp_reg == AW'(MAX_WINDOW - 1)) ? '0 : wp_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= '0;
            wp_reg        <= '0;
            short_sum_reg <= '0;
            long_sum_reg  <= '0;
        end
        else
        begin
            tick_reg      <= tick_next;
            wp_reg        <= wp_next;
            short_sum_reg <= short_sum_next;
            long_sum_reg  <= long_sum_next;
        end
    end

    // Both leaving prices are read when the transaction is taken, before the new price is written.
    always_ff @(posedge clk)
    begin
        if (cmd.update)
            hist_mem[wp_reg] <= price_reg;
        if (cmd.accept)
        begin
            rd_short_reg <= hist_mem[addr_short];
            rd_long_reg  <= hist_mem[addr_long];
        end
    end

    // A window that has not yet filled averages to the current price alone.
    always_comb
    begin
        short_full = tick_reg >= sw_eff;
        long_full  = tick_reg >= lw_eff;
        short_num  = short_full ? short_sum_reg : SUM_W'(price_reg);
        short_den  = short_full ? sw_eff : CNT_W'(1);
        long_num   = long_full ? long_sum_reg : SUM_W'(price_reg);
        long_den   = long_full ? lw_eff : CNT_W'(1);
        a_next     = PROD_W'(short_num) * PROD_W'(long_den);
        b_next     = PROD_W'(long_num) * PROD_W'(short_den);
    end

    // Buy needs 65536*(A-B) > B*theta, sell needs 65536*(B-A) > B*theta.
    always_comb
    begin
        bt_next  = BT_W'(b_reg) * BT_W'(theta_reg);
        gt_next  = a_reg > b_reg;
        mag_next = gt_next ? (a_reg - b_reg) : (b_reg - a_reg);
    end

    always_comb
    begin
        lhs_scaled = {mag_reg, {THETA_W{1'b0}}};
        if (lhs_scaled > bt_reg)
            signal_next = gt_reg ? SIG_BUY : SIG_SELL;
        else
            signal_next = SIG_NONE;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            price_reg <= PRICE_BITS'(open_price);
        if (cmd.mul1)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
        if (cmd.mul2)
        begin
            bt_reg  <= bt_next;
            gt_reg  <= gt_next;
            mag_reg <= mag_next;
        end
        if (cmd.load_out)
            signal_reg <= signal_next;
    end

    assign signal = signal_reg;

endmodule

`default_nettype wire

>>> src/moving_average_crossover_signal.sv
// Top level of the moving-average crossover signal block.
//
// One opening price enters on the input channel (in_valid, in_stall, open_price) and one
// trade signal leaves on the output channel (out_valid, out_stall, signal) for each
// transaction: 0 none, 1 buy, 2 sell. A transaction completes at a rising edge with valid
// high and stall low.
// The history memory read, the sum update, two multiplier steps and the compare run in
// sequence on one price at a time; the next price is not taken before the compare step.
// A finished result waits in the output register; meanwhile the next price is taken. When
// the receiver keeps stalling, the following result holds in the compare step and the
// input stalls until the output register frees.
// Registers are written through cfg_we, cfg_index and cfg_data: theta, short window and
// long window. The user must write them only while the block is idle; the block does not
// enforce this. Writing either window restarts the price history.
// Reset restores the register defaults, empties the history and clears out_valid; no
// clearing pass is needed, so prices are taken straight after reset.
`default_nettype none

module moving_average_crossover_signal
    import macs_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int PRICE_BITS = PRICE_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [PRICE_IN_W-1:0] open_price,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic      [SIG_W-1:0]      signal,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    macs_cmd_t cmd;

    macs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    macs_dp #(
        .MAX_WINDOW (MAX_WINDOW),
        .PRICE_BITS (PRICE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .open_price (open_price),
        .signal     (signal)
    );

endmodule

`default_nettype wire
